FILE: rtl/anxb_pkg.sv
// Shared types and constants for the Annex B NAL unit deframer.
// No dependencies; imported by every module of the block.
package anxb_pkg;

    localparam int MAX_ZERO_RUN = 32;
    localparam int ZRUN_W       = 6;
    localparam int LEN_W        = 21;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [LEN_W-1:0]  UNIT_LIMIT_MAX = LEN_W'(1048576);
    localparam logic [ZRUN_W-1:0] ZRUN_SAT       = ZRUN_W'(MAX_ZERO_RUN);

    // Register index carried on paddr[2]
    localparam logic REG_MAX_UNIT_BYTES = 1'b0;

    typedef enum logic [1:0] {
        HUNT_UNKNOWN = 2'd0,
        HUNT_KNOWN   = 2'd1,
        HUNT_UNIT    = 2'd2
    } hunt_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ZEROS = 2'd1,
        ST_TAIL  = 2'd2
    } ctrl_state_t;

    typedef enum logic [2:0] {
        EMIT_NONE    = 3'd0,
        EMIT_MARKER  = 3'd1,
        EMIT_IN_BYTE = 3'd2,
        EMIT_ZERO    = 3'd3,
        EMIT_HELD    = 3'd4
    } emit_t;

    typedef struct packed {
        logic  take;
        logic  load_flush;
        emit_t emit;
        logic  last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic item_eos;
        logic item_zero;
        logic in_unit;
        logic start_code;
        logic flush_zeros;
        logic at_limit;
        logic near_limit;
        logic zcnt_last;
        logic pend_marker;
    } dp_stat_t;

endpackage

FILE: rtl/anxb_ctrl.sv
// Sequencer for the deframer: accepts items and steps through held-zero flushes.
// Depends on anxb_pkg; drives anxb_dpath through dp_cmd_t.
module anxb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  anxb_pkg::dp_stat_t stat,
    output anxb_pkg::dp_cmd_t  cmd,
    output logic              in_stall
);
    import anxb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.load_flush = 1'b0;
        cmd.emit       = EMIT_NONE;
        cmd.last       = 1'b1;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.take = 1'b1;
                    priority if (stat.item_eos)
                    begin
                        if (stat.in_unit)
                        begin
                            cmd.emit = EMIT_MARKER;
                        end
                    end
                    else if (stat.item_zero || !stat.in_unit)
                    begin
                        cmd.emit = EMIT_NONE;
                    end
                    else if (stat.flush_zeros)
                    begin
                        cmd.load_flush = 1'b1;
                        state_next     = ST_ZEROS;
                    end
                    else if (stat.start_code)
                    begin
                        cmd.emit = EMIT_MARKER;
                    end
                    else
                    begin
                        cmd.emit = EMIT_IN_BYTE;
                    end
                end
            end
            ST_ZEROS:
            begin
                // At the limit the zero is dropped, so no output slot is needed.
                if (stat.at_limit)
                begin
                    cmd.emit   = EMIT_ZERO;
                    state_next = ST_TAIL;
                end
                else if (stat.out_free)
                begin
                    cmd.emit = EMIT_ZERO;
                    // Last only when the held byte behind it will be dropped.
                    cmd.last = !stat.pend_marker && stat.near_limit;
                    if (stat.zcnt_last)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = stat.pend_marker ? EMIT_MARKER : EMIT_HELD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/anxb_dpath.sv
// Datapath for the deframer: scan state, unit counters, held zeros and output register.
// Depends on anxb_pkg; commanded by anxb_ctrl.
module anxb_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  anxb_pkg::dp_cmd_t           cmd,
    output anxb_pkg::dp_stat_t          stat,
    input  logic [anxb_pkg::LEN_W-1:0]  max_unit_bytes,
    input  logic [7:0]                  in_byte,
    input  logic                        stream_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [7:0]                  out_byte,
    output logic [anxb_pkg::LEN_W-1:0]  unit_length,
    output logic                        overflow,
    output logic                        last
);
    import anxb_pkg::*;

    hunt_t             hunt_reg,      hunt_next;
    logic [ZRUN_W-1:0] zero_run_reg,  zero_run_next;
    logic [ZRUN_W-1:0] lead_reg,      lead_next;
    logic [LEN_W-1:0]  count_reg,     count_next;
    logic              ovf_seen_reg,  ovf_seen_next;
    logic [ZRUN_W-1:0] zcnt_reg,      zcnt_next;
    logic              pend_reg,      pend_next;
    logic [7:0]        held_reg,      held_next;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg,      kind_next;
    logic [7:0]        byte_reg,      byte_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic              ovf_reg,       ovf_next;
    logic              last_reg,      last_next;

    logic [LEN_W-1:0]  limit;
    logic [LEN_W:0]    count_inc;
    logic              start_code;
    logic              out_free;
    logic              at_limit;
    logic [7:0]        pay_byte;

    assign limit      = (max_unit_bytes > UNIT_LIMIT_MAX) ? UNIT_LIMIT_MAX : max_unit_bytes;
    assign count_inc  = {1'b0, count_reg} + (LEN_W+1)'(1);
    assign at_limit   = (count_reg >= limit);
    assign start_code = (in_byte == 8'd1) && (zero_run_reg >= ZRUN_W'(2));
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.out_free    = out_free;
        stat.item_eos    = stream_end;
        stat.item_zero   = (in_byte == 8'd0);
        stat.in_unit     = (hunt_reg == HUNT_UNIT);
        stat.start_code  = start_code;
        stat.flush_zeros = start_code ? (zero_run_reg > lead_reg) : (zero_run_reg != '0);
        stat.at_limit    = at_limit;
        stat.near_limit  = (count_inc >= {1'b0, limit});
        stat.zcnt_last   = (zcnt_reg == ZRUN_W'(1));
        stat.pend_marker = pend_reg;
    end

    always_comb
    begin
        unique case (cmd.emit)
            EMIT_IN_BYTE: pay_byte = in_byte;
            EMIT_HELD:    pay_byte = held_reg;
            default:      pay_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        hunt_next      = hunt_reg;
        zero_run_next  = zero_run_reg;
        lead_next      = lead_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        zcnt_next      = zcnt_reg;
        pend_next      = pend_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;

        // Scan bookkeeping for an accepted item
        if (cmd.take)
        begin
            priority if (stream_end)
            begin
                if (hunt_reg == HUNT_UNIT)
                begin
                    hunt_next = HUNT_KNOWN;
                end
                zero_run_next = '0;
            end
            else if (in_byte == 8'd0)
            begin
                if (zero_run_reg < ZRUN_SAT)
                begin
                    zero_run_next = zero_run_reg + ZRUN_W'(1);
                end
            end
            else if (hunt_reg != HUNT_UNIT)
            begin
                if (start_code)
                begin
                    if (hunt_reg != HUNT_KNOWN)
                    begin
                        lead_next = zero_run_reg;
                    end
                    hunt_next     = HUNT_UNIT;
                    count_next    = '0;
                    ovf_seen_next = 1'b0;
                end
                zero_run_next = '0;
            end
            else
            begin
                zero_run_next = '0;
            end
        end

        if (cmd.load_flush)
        begin
            zcnt_next = start_code ? (zero_run_reg - lead_reg) : zero_run_reg;
            pend_next = start_code;
            held_next = in_byte;
        end

        if (cmd.emit == EMIT_ZERO)
        begin
            zcnt_next = zcnt_reg - ZRUN_W'(1);
        end

        unique case (cmd.emit)
            EMIT_NONE:
            begin
            end
            EMIT_MARKER:
            begin
                out_valid_next = 1'b1;
                kind_next      = 1'b1;
                byte_next      = 8'd0;
                len_next       = count_reg;
                ovf_next       = ovf_seen_reg;
                last_next      = 1'b1;
                count_next     = '0;
                ovf_seen_next  = 1'b0;
            end
            default:
            begin
                // Payload byte: drop and flag once the unit is full
                if (at_limit)
                begin
                    ovf_seen_next = 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b0;
                    byte_next      = pay_byte;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    last_next      = cmd.last;
                    count_next     = count_inc[LEN_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg      <= HUNT_UNKNOWN;
            zero_run_reg  <= '0;
            lead_reg      <= '0;
            count_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            zcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hunt_reg      <= hunt_next;
            zero_run_reg  <= zero_run_next;
            lead_reg      <= lead_next;
            count_reg     <= count_next;
            ovf_seen_reg  <= ovf_seen_next;
            zcnt_reg      <= zcnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        len_reg  <= len_next;
        ovf_reg  <= ovf_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_byte    = byte_reg;
    assign unit_length = len_reg;
    assign overflow    = ovf_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/annexb_nal_unit_deframer_unit.sv
// Top level of the Annex B NAL unit deframer: register port, controller and datapath.
// Depends on anxb_pkg, anxb_ctrl and anxb_dpath.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | in        | in_valid / in_stall | in_byte, stream_end
//   out     | out       | out_valid/out_stall | kind, out_byte, unit_length, overflow, last
//   cfg     | in        | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One byte per cycle while no held zeros must be flushed and the output is free.
// A byte that releases held zeros is handled in steps: accepting it loads the
// flush, then each zero and then the closing byte or marker goes out as one result
// (once the unit limit is reached, the remaining zeros are dropped together).
// Reset (rst_n low, asynchronous) clears the scan state and sets max_unit_bytes
// to 1048576. Output stall backs up into in_stall in the same cycle.
module annexb_nal_unit_deframer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_byte,
    input  logic                         stream_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [7:0]                   out_byte,
    output logic [anxb_pkg::LEN_W-1:0]   unit_length,
    output logic                         overflow,
    output logic                         last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [anxb_pkg::ADDR_W-1:0]  paddr,
    input  logic [anxb_pkg::DATA_W-1:0]  pwdata,
    output logic [anxb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import anxb_pkg::*;

    logic [LEN_W-1:0] max_unit_reg;
    logic [LEN_W-1:0] max_unit_next;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // Register port: zero wait states, one register at byte address 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_UNIT_BYTES);

    always_comb
    begin
        max_unit_next = max_unit_reg;
        if (cfg_write)
        begin
            max_unit_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_unit_reg <= UNIT_LIMIT_MAX;
        end
        else
        begin
            max_unit_reg <= max_unit_next;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_UNIT_BYTES) ?
                    {{(DATA_W-LEN_W){1'b0}}, max_unit_reg} : '0;

    // Controller: accepts items, sequences held-zero flush and tail.
    anxb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath: scan state, unit length/overflow tracking, output register.
    anxb_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .max_unit_bytes (max_unit_reg),
        .in_byte        (in_byte),
        .stream_end     (stream_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_byte       (out_byte),
        .unit_length    (unit_length),
        .overflow       (overflow),
        .last           (last)
    );

`ifndef ASSERT_OFF
    // An end marker always closes the item's results and carries no byte.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (last && (out_byte == 8'd0)))
        else $error("end marker without last or with nonzero byte");

    // Payload transfers carry no length and no overflow flag.
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> ((unit_length == '0) && !overflow))
        else $error("payload transfer with length or overflow set");

    // The controller only issues a flush while it holds off input.
    a_flush_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit == EMIT_ZERO || cmd.emit == EMIT_HELD) |-> (in_stall && !cmd.take))
        else $error("zero flush overlapped an input transfer");
`endif

endmodule

FILE: sim/annexb_nal_unit_deframer_unit_test.sv
// Self-checking testbench for the Annex B NAL unit deframer: random and directed byte streams,
// an in-file predictor with a result scoreboard, and an APB write path for the unit limit.
// Depends on anxb_pkg and annexb_nal_unit_deframer_unit.
`timescale 1ns / 100ps

module annexb_nal_unit_deframer_unit_test;

    import anxb_pkg::*;

    // Byte address of the unit limit register (index 0, 32-bit slots)
    localparam logic [ADDR_W-1:0] MAX_UNIT_ADDR = {REG_MAX_UNIT_BYTES, 2'b00};

    // One held-zero release emits one result per held zero; allow for the
    // widest burst plus the output register before touching the limit
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;

    // Directed stream: bit 8 set marks an end-of-stream item, its low byte is ignored
    localparam int NUM_DIRECTED = 30;
    localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
        9'h1A5,                                     // end of stream while hunting
        9'h000, 9'h001,                             // one zero then 01: not a start code
        9'h000, 9'h000, 9'h000, 9'h001,             // first start code, learns three zeros
        9'h0FF, 9'h000, 9'h07F, 9'h000, 9'h001,     // extremes, held zero flushed, 01 as data
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001, // extra zeros become trailing bytes
        9'h0AB, 9'h000, 9'h000, 9'h001,             // start code shorter than the learned one
        9'h1FF,                                     // end of stream right after a start code
        9'h000, 9'h000, 9'h001,                     // start code while hunting with known count
        9'h05A, 9'h000, 9'h000, 9'h100              // end of stream drops the held zeros
    };

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             last;
    } nal_result_t;

    // Tracks the deframer state from accepted bytes and holds the results still due
    class nal_split_tracker;
        hunt_t            mode;
        int               zero_run_len;
        int               lead_zeros;
        int               kept_bytes;
        bit               dropped;
        logic [LEN_W-1:0] max_unit;
        nal_result_t      due[$];
        nal_result_t      newest;
        bit               newest_held;
        int               errors;
        int               results_seen;
        int               markers_seen;

        function new();
            mode         = HUNT_UNKNOWN;
            zero_run_len = 0;
            lead_zeros   = 0;
            kept_bytes   = 0;
            dropped      = 0;
            max_unit     = UNIT_LIMIT_MAX;
            newest_held  = 0;
            errors       = 0;
            results_seen = 0;
            markers_seen = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void set_max_unit(logic [LEN_W-1:0] value);
            max_unit = value;
        endfunction

        // Keep the newest result back so that last can still be raised on it
        function void stage(nal_result_t r);
            if (newest_held)
                due.push_back(newest);
            newest      = r;
            newest_held = 1;
        endfunction

        function void add_payload(logic [7:0] b);
            int          cap;
            nal_result_t r;
            cap = (max_unit > UNIT_LIMIT_MAX) ? int'(UNIT_LIMIT_MAX) : int'(max_unit);
            if (kept_bytes >= cap) begin
                dropped = 1;
                return;
            end
            kept_bytes++;
            r      = '0;
            r.data = b;
            stage(r);
        endfunction

        function void add_marker();
            nal_result_t r;
            r      = '0;
            r.kind = 1'b1;
            r.len  = LEN_W'(kept_bytes);
            r.ovf  = dropped;
            stage(r);
            kept_bytes = 0;
            dropped    = 0;
        endfunction

        function void take_byte(logic [7:0] b, logic eos);
            if (eos) begin
                if (mode == HUNT_UNIT) begin
                    add_marker();
                    mode = HUNT_KNOWN;
                end
                zero_run_len = 0;
            end else if (b == 8'h00) begin
                if (zero_run_len < MAX_ZERO_RUN)
                    zero_run_len++;
            end else if (mode != HUNT_UNIT) begin
                if (b == 8'h01 && zero_run_len >= 2) begin
                    if (mode != HUNT_KNOWN)
                        lead_zeros = zero_run_len;
                    mode       = HUNT_UNIT;
                    kept_bytes = 0;
                    dropped    = 0;
                end
                zero_run_len = 0;
            end else if (b == 8'h01 && zero_run_len >= 2) begin
                while (zero_run_len > lead_zeros) begin
                    add_payload(8'h00);
                    zero_run_len--;
                end
                zero_run_len = 0;
                add_marker();
            end else begin
                while (zero_run_len > 0) begin
                    add_payload(8'h00);
                    zero_run_len--;
                end
                add_payload(b);
            end
            if (newest_held) begin
                newest.last = 1'b1;
                due.push_back(newest);
                newest_held = 0;
            end
        endfunction

        function string show(nal_result_t r);
            return $sformatf("kind=%0d byte=%02h len=%0d ovf=%0d last=%0d",
                             r.kind, r.data, r.len, r.ovf, r.last);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %0d at %0t: %s", errors, $time, msg);
        endfunction

        function void match_result(nal_result_t got);
            nal_result_t want;
            results_seen++;
            if (got.kind)
                markers_seen++;
            if (due.size() == 0) begin
                flag($sformatf("result with nothing expected: %s", show(got)));
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.len !== want.len
                || got.ovf !== want.ovf || got.last !== want.last)
                flag($sformatf("expected %s, got %s", show(want), show(got)));
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [7:0]          in_byte       = 8'h00;
    logic                stream_end    = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                kind;
    logic [7:0]          out_byte;
    logic [LEN_W-1:0]    unit_length;
    logic                overflow;
    logic                last;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    nal_split_tracker    sb;
    int                  items_in      = 0;
    int                  limits_set    = 0;
    bit                  tx_idle_on    = 1'b0;
    bit                  rx_idle_on    = 1'b0;
    bit                  long_hold_req = 1'b0;

    annexb_nal_unit_deframer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .stream_end    (stream_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .out_byte      (out_byte),
        .unit_length   (unit_length),
        .overflow      (overflow),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item and hold it until a transfer happens; then maybe idle the sender
    task automatic offer_item(input logic [7:0] b, input logic eos);
        in_valid   <= 1'b1;
        in_byte    <= b;
        stream_end <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_byte(b, eos);
        items_in++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Payload bytes lean toward zeros and 01 so held runs and false start codes show up
    function automatic logic [7:0] pick_payload();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return 8'h00;
        if (roll == 3)
            return 8'h01;
        return 8'($urandom_range(0, 255));
    endfunction

    // Open a unit, then a zero run long enough to saturate the counter, then close it;
    // the zeros beyond the learned count come out as trailing payload
    task automatic offer_zero_flood();
        repeat (2) offer_item(8'h00, 1'b0);
        offer_item(8'h01, 1'b0);
        offer_item(pick_payload(), 1'b0);
        repeat ($urandom_range(33, 40)) offer_item(8'h00, 1'b0);
        offer_item(8'h01, 1'b0);
    endtask

    // Mostly well-formed units with random content; some end-of-stream items and noise
    task automatic offer_stream(input int count);
        int stop;
        int pick;
        int zeros;
        stop = items_in + count;
        while (items_in < stop) begin
            pick = $urandom_range(0, 29);
            if (pick < 20) begin
                zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(2, 4);
                repeat (zeros) offer_item(8'h00, 1'b0);
                offer_item(8'h01, 1'b0);
                repeat ($urandom_range(0, 10)) offer_item(pick_payload(), 1'b0);
            end else if (pick < 23) begin
                offer_item(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick == 23) begin
                offer_zero_flood();
            end else begin
                repeat ($urandom_range(1, 4))
                    offer_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Drop valid, wait for every expected result, then let any pending flush finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_max_unit(input logic [LEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_UNIT_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_max_unit(value);
        limits_set++;
    endtask

    // Receiver: random stall bursts while enabled; one long hold on request,
    // counted here while the sender keeps offering bytes
    initial
    begin : out_stall_gen
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall     <= 1'b0;
                long_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_result({kind, out_byte, unit_length, overflow, last});
    end

    initial
    begin : main_seq
        int fails;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: directed stream, one saturating zero run, then random units
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_item(DIRECTED[i][7:0], DIRECTED[i][8]);
        offer_zero_flood();
        offer_stream(25);
        settle();

        // Limit of one byte; sender never idles here
        tx_idle_on = 1'b0;
        write_max_unit(LEN_W'(1));
        offer_stream(20);
        settle();

        // Zero limit: every payload byte is dropped, only markers come out
        tx_idle_on = 1'b1;
        write_max_unit(LEN_W'(0));
        offer_stream(15);
        settle();

        // Small limit under a long receiver hold so the block backs up into its input
        write_max_unit(LEN_W'(5));
        long_hold_req = 1'b1;
        offer_stream(30);
        settle();

        // All ones: above the largest unit, so the cap applies
        write_max_unit({LEN_W{1'b1}});
        offer_stream(20);
        settle();

        // Largest limit at full rate, no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_max_unit(UNIT_LIMIT_MAX);
        offer_stream(25);
        settle();

        fails = sb.errors + sb.pending();
        $display("covered %0d byte transfers and %0d result transfers (%0d unit markers)",
                 items_in, sb.results_seen, sb.markers_seen);
        $display("unit limit written %0d times, from zero to all ones; %0d mismatches",
                 limits_set, sb.errors);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #8000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/anxb_pkg.sv
rtl/anxb_ctrl.sv
rtl/anxb_dpath.sv
rtl/annexb_nal_unit_deframer_unit.sv
sim/annexb_nal_unit_deframer_unit_test.sv
